@@ rtl/smt_pkg.sv @@
// Shared types and constants for the sphere-map texture coordinate generator.
// Holds the item structs, fixed-point widths and register indexes.
// No dependencies.
package smt_pkg;

  localparam int COORD_W       = 16;
  localparam int COEF_W        = 16;
  localparam int REG_W         = 4 * COEF_W;
  localparam int IDX_W         = 2;
  localparam int INPUT_FRAC    = 8;
  localparam int UNIT_FRAC     = 30;
  localparam int UNIT_W        = UNIT_FRAC + 2;
  localparam int XF_W          = 34;
  localparam int R_W           = 36;
  localparam int TEX_W         = 16;
  localparam int COEF_FRAC_DEF = 12;
  localparam int M_NEAR_ZERO   = 128;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } reg_idx_t;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;
  } vtx_item_t;

  typedef struct packed {
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic             degenerate;
  } tex_item_t;

endpackage

@@ rtl/smt_isqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, floor result.
// Carries a side tag alongside each item.
// No package dependencies.
module smt_isqrt_pipe #(
  parameter int IN_W  = 62,
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_x,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int S  = IN_W / 2;
  localparam int RW = S + 2;

  logic             st_valid [S];
  logic [IN_W-1:0]  st_x     [S];
  logic [RW-1:0]    st_rem   [S];
  logic [S-1:0]     st_root  [S];
  logic [TAG_W-1:0] st_tag   [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic             v_in;
    logic [IN_W-1:0]  x_in;
    logic [RW-1:0]    rem_in;
    logic [S-1:0]     root_in;
    logic [TAG_W-1:0] tag_in;
    logic [RW+1:0]    r4;
    logic [RW+1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_x;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = st_valid[k-1];
      assign x_in    = st_x[k-1];
      assign rem_in  = st_rem[k-1];
      assign root_in = st_root[k-1];
      assign tag_in  = st_tag[k-1];
    end

    assign r4    = {rem_in, x_in[IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= v_in;
      end
      if (en) begin
        st_x[k]    <= {x_in[IN_W-3:0], 2'b00};
        st_rem[k]  <= ge ? RW'(r4 - trial) : RW'(r4);
        st_root[k] <= {root_in[S-2:0], ge};
        st_tag[k]  <= tag_in;
      end
    end
  end

  assign out_valid = st_valid[S-1];
  assign out_root  = st_root[S-1];
  assign out_tag   = st_tag[S-1];

endmodule

@@ rtl/smt_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, floor result.
// Caller supplies the leading partial remainder, below the divisor.
// No package dependencies.
module smt_div_pipe #(
  parameter int QW    = 31,
  parameter int DEN_W = 31,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [QW-1:0]    in_low,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             st_valid [QW];
  logic [DEN_W-1:0] st_rem   [QW];
  logic [QW-1:0]    st_low   [QW];
  logic [DEN_W-1:0] st_den   [QW];
  logic [QW-1:0]    st_quo   [QW];
  logic [TAG_W-1:0] st_tag   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [QW-1:0]    low_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   dx;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_rem;
      assign low_in = in_low;
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = st_valid[k-1];
      assign rem_in = st_rem[k-1];
      assign low_in = st_low[k-1];
      assign den_in = st_den[k-1];
      assign quo_in = st_quo[k-1];
      assign tag_in = st_tag[k-1];
    end

    assign r2 = {rem_in, low_in[QW-1]};
    assign dx = {1'b0, den_in};
    assign ge = (r2 >= dx);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= v_in;
      end
      if (en) begin
        st_rem[k] <= ge ? DEN_W'(r2 - dx) : DEN_W'(r2);
        st_low[k] <= {low_in[QW-2:0], 1'b0};
        st_den[k] <= den_in;
        st_quo[k] <= {quo_in[QW-2:0], ge};
        st_tag[k] <= tag_in;
      end
    end
  end

  assign out_valid = st_valid[QW-1];
  assign out_quo   = st_quo[QW-1];
  assign out_tag   = st_tag[QW-1];

endmodule

@@ rtl/smt_norm.sv @@
// Pipelined 3-vector normalizer to signed Q1.30 unit components.
// Depends on smt_pkg, smt_isqrt_pipe and smt_div_pipe.
module smt_norm #(
  parameter int VW = 34
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [VW-1:0]   in_vec [3],
  output logic                   out_valid,
  output smt_pkg::unit_t         out_vec [3]
);
  import smt_pkg::*;

  localparam int PW     = $clog2(VW);
  localparam int TOP    = UNIT_FRAC - 1;
  localparam int MW     = UNIT_FRAC;
  localparam int SQ_W   = 2 * MW;
  localparam int SUM_W  = SQ_W + 2;
  localparam int LEN_W  = SUM_W / 2;
  localparam int QW     = UNIT_W - 1;
  localparam int STAG_W = 4 + 3 * MW;

  function automatic logic [PW-1:0] msb_pos(input logic [VW-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int b = 0; b < VW; b++) begin
      if (v[b]) p = PW'(b);
    end
    return p;
  endfunction

  logic          n1_v, n2_v, n3_v, n4_v, n5_v, n6_v;
  logic [2:0]    n1_neg, n2_neg, n3_neg, n4_neg, n5_neg, n6_neg;
  logic [VW-1:0] n1_mag [3];
  logic [VW-1:0] n2_mag [3];
  logic [VW-1:0] n3_mag [3];
  logic [VW-1:0] n2_mx;
  logic [PW-1:0] n3_pos;
  logic          n3_zero, n4_zero, n5_zero, n6_zero;
  logic [VW-1:0] sh_full [3];
  logic [MW-1:0] n4_mag [3];
  logic [MW-1:0] n5_mag [3];
  logic [MW-1:0] n6_mag [3];
  logic [SQ_W-1:0]  n5_sq [3];
  logic [SUM_W-1:0] n6_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (n3_pos >= PW'(TOP)) begin
        sh_full[i] = n3_mag[i] >> (n3_pos - PW'(TOP));
      end else begin
        sh_full[i] = n3_mag[i] << (PW'(TOP) - n3_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
      n3_v <= 1'b0;
      n4_v <= 1'b0;
      n5_v <= 1'b0;
      n6_v <= 1'b0;
    end else if (en) begin
      n1_v <= in_valid;
      n2_v <= n1_v;
      n3_v <= n2_v;
      n4_v <= n3_v;
      n5_v <= n4_v;
      n6_v <= n5_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n1_neg[i] <= in_vec[i][VW-1];
        n1_mag[i] <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
        n2_mag[i] <= n1_mag[i];
        n3_mag[i] <= n2_mag[i];
        n4_mag[i] <= sh_full[i][MW-1:0];
        n5_mag[i] <= n4_mag[i];
        n6_mag[i] <= n5_mag[i];
        n5_sq[i]  <= SQ_W'(n4_mag[i]) * SQ_W'(n4_mag[i]);
      end
      n2_neg <= n1_neg;
      n3_neg <= n2_neg;
      n4_neg <= n3_neg;
      n5_neg <= n4_neg;
      n6_neg <= n5_neg;
      if (n1_mag[0] >= n1_mag[1] && n1_mag[0] >= n1_mag[2]) begin
        n2_mx <= n1_mag[0];
      end else if (n1_mag[1] >= n1_mag[2]) begin
        n2_mx <= n1_mag[1];
      end else begin
        n2_mx <= n1_mag[2];
      end
      n3_pos  <= msb_pos(n2_mx);
      n3_zero <= (n2_mx == '0);
      n4_zero <= n3_zero;
      n5_zero <= n4_zero;
      n6_zero <= n5_zero;
      n6_sum  <= SUM_W'(n5_sq[0]) + SUM_W'(n5_sq[1]) + SUM_W'(n5_sq[2]);
    end
  end

  logic [STAG_W-1:0] sq_tag_in, sq_tag_out;
  logic              sq_v;
  logic [LEN_W-1:0]  sq_len;
  logic [2:0]        sq_neg;
  logic              sq_zero;
  logic [MW-1:0]     sq_mag [3];

  assign sq_tag_in = {n6_neg, n6_zero, n6_mag[0], n6_mag[1], n6_mag[2]};

  smt_isqrt_pipe #(
    .IN_W  (SUM_W),
    .TAG_W (STAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n6_v),
    .in_x      (n6_sum),
    .in_tag    (sq_tag_in),
    .out_valid (sq_v),
    .out_root  (sq_len),
    .out_tag   (sq_tag_out)
  );

  assign {sq_neg, sq_zero, sq_mag[0], sq_mag[1], sq_mag[2]} = sq_tag_out;

  logic          dv_v   [3];
  logic [QW-1:0] dv_quo [3];
  logic [1:0]    dv_tag [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    smt_div_pipe #(
      .QW    (QW),
      .DEN_W (LEN_W),
      .TAG_W (2)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_v),
      .in_rem    (LEN_W'(sq_mag[i] >> 1)),
      .in_low    ({sq_mag[i][0], {(QW-1){1'b0}}}),
      .in_den    (sq_len),
      .in_tag    ({sq_neg[i], sq_zero}),
      .out_valid (dv_v[i]),
      .out_quo   (dv_quo[i]),
      .out_tag   (dv_tag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[0];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_tag[i][0]) begin
          out_vec[i] <= '0;
        end else if (dv_tag[i][1]) begin
          out_vec[i] <= -unit_t'({1'b0, dv_quo[i]});
        end else begin
          out_vec[i] <= unit_t'({1'b0, dv_quo[i]});
        end
      end
    end
  end

endmodule

@@ rtl/smt_coord.sv @@
// Sphere-map scale m and saturated s/t coordinates from the unit reflection.
// Depends on smt_pkg, smt_isqrt_pipe and smt_div_pipe.
module smt_coord (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  smt_pkg::unit_t     in_q [3],
  output logic               out_valid,
  output smt_pkg::tex_item_t out_item
);
  import smt_pkg::*;

  localparam int AQ_W  = UNIT_W - 1;
  localparam int SQ_W  = 2 * UNIT_W;
  localparam int RT_W  = SQ_W / 2;
  localparam int M_W   = RT_W + 1;
  localparam int QW    = TEX_W + 1;
  localparam int STAG_W = 2 + 2 * AQ_W;
  localparam logic [M_W-1:0] M_ONE  = M_W'(64'd1 << UNIT_FRAC);
  localparam logic [M_W-1:0] M_LOW  = M_W'(M_NEAR_ZERO);
  localparam logic [QW-1:0]  HALF   = QW'(64'd1 << (TEX_W - 1));
  localparam unit_t          Q_ONE  = UNIT_W'(64'd1 << UNIT_FRAC);

  function automatic logic [TEX_W-1:0] to_tex(input logic neg, input logic ovf,
                                              input logic [QW-1:0] qm);
    logic [TEX_W-1:0] v;
    if (!neg) begin
      if (ovf || qm >= HALF) v = '1;
      else v = TEX_W'(qm + HALF);
    end else begin
      if (ovf || qm > HALF) v = '0;
      else v = TEX_W'(HALF - qm);
    end
    return v;
  endfunction

  logic            c1_v, c2_v, c3_v;
  logic [1:0]      c1_neg, c2_neg, c3_neg;
  logic [AQ_W-1:0] c1_aq [2];
  logic [AQ_W-1:0] c2_aq [2];
  logic [AQ_W-1:0] c3_aq [2];
  logic [UNIT_W-1:0] c1_zp;
  logic [SQ_W-1:0] c2_sq [3];
  logic [SQ_W-1:0] c3_sum;
  unit_t           zp_sum;

  assign zp_sum = in_q[2] + Q_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
    end else if (en) begin
      c1_v <= in_valid;
      c2_v <= c1_v;
      c3_v <= c2_v;
    end
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        c1_neg[i] <= in_q[i][UNIT_W-1];
        c1_aq[i]  <= in_q[i][UNIT_W-1] ? AQ_W'(-in_q[i]) : AQ_W'(in_q[i]);
        c2_aq[i]  <= c1_aq[i];
        c3_aq[i]  <= c2_aq[i];
        c2_sq[i]  <= SQ_W'(c1_aq[i]) * SQ_W'(c1_aq[i]);
      end
      c1_zp    <= zp_sum;
      c2_sq[2] <= SQ_W'(c1_zp) * SQ_W'(c1_zp);
      c2_neg   <= c1_neg;
      c3_neg   <= c2_neg;
      c3_sum   <= c2_sq[0] + c2_sq[1] + c2_sq[2];
    end
  end

  logic              sq_v;
  logic [RT_W-1:0]   sq_root;
  logic [STAG_W-1:0] sq_tag_out;
  logic [1:0]        sq_neg;
  logic [AQ_W-1:0]   sq_aq [2];

  smt_isqrt_pipe #(
    .IN_W  (SQ_W),
    .TAG_W (STAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c3_v),
    .in_x      (c3_sum),
    .in_tag    ({c3_neg, c3_aq[0], c3_aq[1]}),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag_out)
  );

  assign {sq_neg, sq_aq[0], sq_aq[1]} = sq_tag_out;

  logic            c4_v, c5_v;
  logic [M_W-1:0]  m_raw;
  logic [M_W-1:0]  c4_m;
  logic            c4_deg, c5_deg;
  logic [1:0]      c4_neg, c5_neg;
  logic [AQ_W-1:0] c4_aq [2];
  logic [1:0]      c5_ovf;
  logic [M_W-1:0]  c5_rem [2];
  logic [QW-1:0]   c5_low [2];
  logic [M_W-1:0]  c5_m;
  logic [M_W-1:0]  half_aq [2];

  assign m_raw = {sq_root, 1'b0};
  assign half_aq[0] = M_W'(c4_aq[0] >> 1);
  assign half_aq[1] = M_W'(c4_aq[1] >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      c4_v <= 1'b0;
      c5_v <= 1'b0;
    end else if (en) begin
      c4_v <= sq_v;
      c5_v <= c4_v;
    end
    if (en) begin
      c4_deg <= (m_raw <= M_LOW);
      c4_m   <= (m_raw <= M_LOW) ? M_ONE : m_raw;
      c4_neg <= sq_neg;
      c5_neg <= c4_neg;
      c5_deg <= c4_deg;
      c5_m   <= c4_m;
      for (int i = 0; i < 2; i++) begin
        c4_aq[i]  <= sq_aq[i];
        c5_ovf[i] <= (half_aq[i] >= c4_m);
        c5_rem[i] <= (half_aq[i] >= c4_m) ? '0 : half_aq[i];
        c5_low[i] <= {c4_aq[i][0], {(QW-1){1'b0}}};
      end
    end
  end

  logic          dv_v   [2];
  logic [QW-1:0] dv_quo [2];
  logic [2:0]    dv_tag [2];

  for (genvar i = 0; i < 2; i++) begin : g_div
    smt_div_pipe #(
      .QW    (QW),
      .DEN_W (M_W),
      .TAG_W (3)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c5_v),
      .in_rem    (c5_rem[i]),
      .in_low    (c5_low[i]),
      .in_den    (c5_m),
      .in_tag    ({c5_neg[i], c5_ovf[i], c5_deg}),
      .out_valid (dv_v[i]),
      .out_quo   (dv_quo[i]),
      .out_tag   (dv_tag[i])
    );
  end

  assign out_valid           = dv_v[0];
  assign out_item.tex_s      = to_tex(dv_tag[0][2], dv_tag[0][1], dv_quo[0]);
  assign out_item.tex_t      = to_tex(dv_tag[1][2], dv_tag[1][1], dv_quo[1]);
  assign out_item.degenerate = dv_tag[0][0];

endmodule

@@ rtl/sphere_map_texcoord_gen_top.sv @@
// Sphere-map texture coordinate generator top: matrix registers, transform,
// reflection and output register. Depends on smt_pkg, smt_norm, smt_coord.
//
//   channel | signals                              | dir | item
//   vtx     | vtx_valid, vtx_stall, vtx_data       | in  | position and normal, Q8.8
//   tex     | tex_valid, tex_stall, tex_data       | out | s, t (Q0.16), degenerate
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | in  | one 64-bit matrix row
//
// One item per cycle sustained unless the output is held; the depth is set by the
// bit-per-stage square-root and divider pipelines of the three normalizers and m.
// Reset is synchronous and clears all valid bits and the matrix to identity.
// A held result stalls the pipeline only when the stage behind it also holds an item.
// cfg_ready is always high; writes to an index past the last row are dropped.
module sphere_map_texcoord_gen_top #(
  parameter int COEF_FRAC_BITS = smt_pkg::COEF_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vtx_valid,
  output logic                           vtx_stall,
  input  smt_pkg::vtx_item_t             vtx_data,
  output logic                           tex_valid,
  input  logic                           tex_stall,
  output smt_pkg::tex_item_t             tex_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [smt_pkg::IDX_W-1:0]      cfg_index,
  input  logic [smt_pkg::REG_W-1:0]      cfg_data
);
  import smt_pkg::*;

  localparam int PROD_W = COEF_W + COORD_W;
  localparam int PR_W   = 2 * UNIT_W;
  localparam int D_W    = XF_W;
  localparam int PD_W   = D_W + UNIT_W;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic [REG_W-1:0]  ROW_X_RST = REG_W'(COEF_ONE);
  localparam logic [REG_W-1:0]  ROW_Y_RST = REG_W'(COEF_ONE) << COEF_W;
  localparam logic [REG_W-1:0]  ROW_Z_RST = REG_W'(COEF_ONE) << (2 * COEF_W);
  localparam logic signed [PR_W-1:0] DOT_RND = PR_W'((64'sd1 <<< UNIT_FRAC) - 64'sd1);
  localparam logic signed [PD_W-1:0] RFL_RND =
    PD_W'((64'sd1 <<< (UNIT_FRAC - 1)) - 64'sd1);

  logic [REG_W-1:0] matrix_row_x, matrix_row_y, matrix_row_z;
  logic [REG_W-1:0] rows [3];
  logic             en;
  logic             pre_valid;
  tex_item_t        pre_item;

  assign cfg_ready = 1'b1;
  assign rows[0]   = matrix_row_x;
  assign rows[1]   = matrix_row_y;
  assign rows[2]   = matrix_row_z;
  assign en        = !(tex_valid && tex_stall && pre_valid);
  assign vtx_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row_x <= ROW_X_RST;
      matrix_row_y <= ROW_Y_RST;
      matrix_row_z <= ROW_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_X: matrix_row_x <= cfg_data;
        REG_ROW_Y: matrix_row_y <= cfg_data;
        REG_ROW_Z: matrix_row_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // transform
  logic signed [COORD_W-1:0] pv [3];
  logic signed [COORD_W-1:0] nv [3];
  logic                      t1_v, t2_v;
  logic signed [PROD_W-1:0]  t1_pe [3][3];
  logic signed [PROD_W-1:0]  t1_pw [3][3];
  logic signed [COEF_W-1:0]  t1_tr [3];
  logic signed [XF_W-1:0]    t2_e [3];
  logic signed [XF_W-1:0]    t2_w [3];

  assign pv[0] = vtx_data.pos_x;
  assign pv[1] = vtx_data.pos_y;
  assign pv[2] = vtx_data.pos_z;
  assign nv[0] = vtx_data.norm_x;
  assign nv[1] = vtx_data.norm_y;
  assign nv[2] = vtx_data.norm_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
    end else if (en) begin
      t1_v <= vtx_valid;
      t2_v <= t1_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t1_pe[i][j] <= PROD_W'(signed'(rows[i][COEF_W*j +: COEF_W])) * PROD_W'(pv[j]);
          t1_pw[i][j] <= PROD_W'(signed'(rows[i][COEF_W*j +: COEF_W])) * PROD_W'(nv[j]);
        end
        t1_tr[i] <= signed'(rows[i][COEF_W*3 +: COEF_W]);
        t2_e[i]  <= (XF_W'(t1_tr[i]) <<< INPUT_FRAC) + XF_W'(t1_pe[i][0])
                    + XF_W'(t1_pe[i][1]) + XF_W'(t1_pe[i][2]);
        t2_w[i]  <= XF_W'(t1_pw[i][0]) + XF_W'(t1_pw[i][1]) + XF_W'(t1_pw[i][2]);
      end
    end
  end

  logic  u_v, wn_v;
  unit_t u_vec  [3];
  unit_t wn_vec [3];

  smt_norm #(.VW(XF_W)) u_norm_pos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t2_v),
    .in_vec    (t2_e),
    .out_valid (u_v),
    .out_vec   (u_vec)
  );

  smt_norm #(.VW(XF_W)) u_norm_nrm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t2_v),
    .in_vec    (t2_w),
    .out_valid (wn_v),
    .out_vec   (wn_vec)
  );

  // reflection r = u - 2 (wn.u) wn
  logic                   r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
  logic signed [PR_W-1:0] r1_pr [3];
  logic signed [PR_W-1:0] r2_dot;
  logic signed [PR_W-1:0] dot_adj;
  logic signed [D_W-1:0]  r3_d;
  logic signed [PD_W-1:0] r4_pd [3];
  logic signed [PD_W-1:0] pd_adj [3];
  logic signed [R_W-1:0]  r5_t [3];
  logic signed [R_W-1:0]  r6_r [3];
  unit_t r1_u [3];
  unit_t r2_u [3];
  unit_t r3_u [3];
  unit_t r4_u [3];
  unit_t r5_u [3];
  unit_t r1_wn [3];
  unit_t r2_wn [3];
  unit_t r3_wn [3];

  assign dot_adj = r2_dot + (r2_dot[PR_W-1] ? DOT_RND : PR_W'(0));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd_adj[i] = r4_pd[i] + (r4_pd[i][PD_W-1] ? RFL_RND : PD_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
      r3_v <= 1'b0;
      r4_v <= 1'b0;
      r5_v <= 1'b0;
      r6_v <= 1'b0;
    end else if (en) begin
      r1_v <= u_v & wn_v;
      r2_v <= r1_v;
      r3_v <= r2_v;
      r4_v <= r3_v;
      r5_v <= r4_v;
      r6_v <= r5_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r1_pr[i] <= PR_W'(u_vec[i]) * PR_W'(wn_vec[i]);
        r1_u[i]  <= u_vec[i];
        r2_u[i]  <= r1_u[i];
        r3_u[i]  <= r2_u[i];
        r4_u[i]  <= r3_u[i];
        r5_u[i]  <= r4_u[i];
        r1_wn[i] <= wn_vec[i];
        r2_wn[i] <= r1_wn[i];
        r3_wn[i] <= r2_wn[i];
        r4_pd[i] <= PD_W'(r3_d) * PD_W'(r3_wn[i]);
        r5_t[i]  <= R_W'(pd_adj[i] >>> (UNIT_FRAC - 1));
        r6_r[i]  <= R_W'(r5_u[i]) - r5_t[i];
      end
      r2_dot <= r1_pr[0] + r1_pr[1] + r1_pr[2];
      r3_d   <= D_W'(dot_adj >>> UNIT_FRAC);
    end
  end

  logic  q_v;
  unit_t q_vec [3];

  smt_norm #(.VW(R_W)) u_norm_rfl (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r6_v),
    .in_vec    (r6_r),
    .out_valid (q_v),
    .out_vec   (q_vec)
  );

  logic      cd_v;
  tex_item_t cd_item;

  smt_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_v),
    .in_q      (q_vec),
    .out_valid (cd_v),
    .out_item  (cd_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (en) begin
      pre_valid <= cd_v;
    end
    if (en) begin
      pre_item <= cd_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_valid <= 1'b0;
    end else if (!(tex_valid && tex_stall)) begin
      tex_valid <= pre_valid;
    end
    if (!(tex_valid && tex_stall)) begin
      tex_data <= pre_item;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    vtx_stall |-> (tex_valid && tex_stall && pre_valid))
    else $error("input stalled while the output side could advance");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (pre_valid && tex_valid && tex_stall) |=> (pre_valid && $stable(pre_item)))
    else $error("item behind the output register was lost");

  a_matrix_reset: assert property (@(posedge clk)
    rst |=> (matrix_row_x == ROW_X_RST && matrix_row_y == ROW_Y_RST
             && matrix_row_z == ROW_Z_RST))
    else $error("matrix rows not at identity after reset");
`endif

endmodule

@@ sim/sphere_map_texcoord_gen_top_tb.sv @@
// Self-checking testbench for sphere_map_texcoord_gen_top: fixed-point sphere-map predictor,
// matrix rows written between phases, random idling and a long output hold-off.
// Depends on smt_pkg and the RTL of the block.
module sphere_map_texcoord_gen_top_tb;
  import smt_pkg::*;

  localparam int LIMIT = 300000;
  localparam int DRAIN = 220;

  class texcoord_scoreboard;
    tex_item_t coords_due[$];
    logic [REG_W-1:0] rows [3];
    int errors;
    int checked;
    int degen_seen;

    function new();
      rows[0] = 64'h0000_0000_0000_1000;
      rows[1] = 64'h0000_0000_1000_0000;
      rows[2] = 64'h0000_1000_0000_0000;
    endfunction

    task report(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, checked);
      errors++;
    endtask

    function void write_row(input reg_idx_t idx, input logic [REG_W-1:0] val);
      if (idx == REG_ROW_X || idx == REG_ROW_Y || idx == REG_ROW_Z) rows[idx] = val;
    endfunction

    function longint unsigned isqrt(input longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void unitize(input longint v [3], output longint o [3]);
      longint unsigned mag [3];
      longint unsigned mx, sum, len;
      bit neg [3];
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? longint'(-v[i]) : v[i];
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return;
      end
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        o[i] = longint'((mag[i] << 30) / len);
        if (neg[i]) o[i] = -o[i];
      end
    endfunction

    function logic [TEX_W-1:0] to_coord(input longint num, input longint m);
      longint v;
      v = (num * 65536) / m + 32768;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[TEX_W-1:0];
    endfunction

    function void note_vertex(input vtx_item_t it);
      longint p [3], n [3], e [3], w [3], u [3], wn [3], r [3], q [3];
      longint c, d, m, zp;
      longint unsigned sum;
      tex_item_t want;
      p[0] = it.pos_x;  p[1] = it.pos_y;  p[2] = it.pos_z;
      n[0] = it.norm_x; n[1] = it.norm_y; n[2] = it.norm_z;
      for (int i = 0; i < 3; i++) begin
        c = $signed(rows[i][48 +: 16]);
        e[i] = c * 256;
        w[i] = 0;
        for (int j = 0; j < 3; j++) begin
          c = $signed(rows[i][j*16 +: 16]);
          e[i] += c * p[j];
          w[i] += c * n[j];
        end
      end
      unitize(e, u);
      unitize(w, wn);
      d = 0;
      for (int i = 0; i < 3; i++) d += wn[i] * u[i];
      d = d / 64'sd1073741824;
      for (int i = 0; i < 3; i++) r[i] = u[i] - (d * wn[i]) / 64'sd536870912;
      unitize(r, q);
      zp = q[2] + 64'sd1073741824;
      sum = longint'(q[0] * q[0]) + longint'(q[1] * q[1]) + longint'(zp * zp);
      m = 2 * longint'(isqrt(sum));
      want.degenerate = m <= M_NEAR_ZERO;
      if (want.degenerate) m = 64'sd1073741824;
      want.tex_s = to_coord(q[0], m);
      want.tex_t = to_coord(q[1], m);
      coords_due.push_back(want);
    endfunction

    task check_coords(input tex_item_t got);
      tex_item_t want;
      if (coords_due.size() == 0) begin
        report("unexpected item", int'(got.tex_s), 0);
        return;
      end
      want = coords_due.pop_front();
      if (got.tex_s !== want.tex_s) report("tex_s", int'(got.tex_s), int'(want.tex_s));
      if (got.tex_t !== want.tex_t) report("tex_t", int'(got.tex_t), int'(want.tex_t));
      if (got.degenerate !== want.degenerate)
        report("degenerate", int'(got.degenerate), int'(want.degenerate));
      if (want.degenerate) degen_seen++;
      checked++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic vtx_valid = 0;
  logic vtx_stall;
  vtx_item_t vtx_data = '0;
  logic tex_valid;
  logic tex_stall = 0;
  tex_item_t tex_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  logic hold_out = 0;
  logic calm = 0;
  int sent = 0;
  int cycles = 0;
  int settings = 0;
  texcoord_scoreboard sb = new();

  sphere_map_texcoord_gen_top DUT (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx_data(vtx_data),
    .tex_valid(tex_valid), .tex_stall(tex_stall), .tex_data(tex_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && tex_valid && !tex_stall) sb.check_coords(tex_data);
    tex_stall <= hold_out || (!calm && $urandom_range(0, 99) < 6);
  end

  initial begin
    wait (sent >= 300);
    @(posedge clk);
    hold_out <= 1;
    repeat (600) @(posedge clk);
    hold_out <= 0;
  end

  task send_vertex(input vtx_item_t it);
    vtx_valid <= 1;
    vtx_data <= it;
    do @(posedge clk); while (vtx_stall);
    sb.note_vertex(it);
    sent++;
    if (!calm && $urandom_range(0, 99) < 6) begin
      vtx_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    vtx_valid <= 0;
    while (sb.coords_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_row(reg_idx_t'(idx), val);
    cfg_valid <= 0;
  endtask

  task load_matrix(input logic [REG_W-1:0] rx, ry, rz);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    settings++;
  endtask

  function automatic logic [15:0] pick_coord(input bit narrow);
    if (narrow) return 16'($signed($urandom_range(0, 1024)) - 512);
    return 16'($urandom);
  endfunction

  task random_vertices(input int count);
    vtx_item_t it;
    bit narrow;
    for (int k = 0; k < count; k++) begin
      narrow = $urandom_range(0, 9) < 3;
      it.pos_x = pick_coord(narrow);
      it.pos_y = pick_coord(narrow);
      it.pos_z = pick_coord(narrow);
      it.norm_x = pick_coord(narrow);
      it.norm_y = pick_coord(narrow);
      it.norm_z = pick_coord(narrow);
      if ($urandom_range(0, 19) == 0) {it.norm_x, it.norm_y, it.norm_z} = '0;
      send_vertex(it);
    end
  endtask

  function automatic logic [REG_W-1:0] random_row();
    if ($urandom_range(0, 1)) return {$urandom, $urandom};
    return {16'($signed($urandom_range(0, 8192)) - 4096),
            16'($signed($urandom_range(0, 8192)) - 4096),
            16'($signed($urandom_range(0, 8192)) - 4096),
            16'($signed($urandom_range(0, 8192)) - 4096)};
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_vertex('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_vertex('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_vertex('{16'sh7fff, 16'sh8000, 16'sh0001, 16'sh8000, 16'sh7fff, 16'shffff});
    send_vertex('{0, 0, 0, 0, 0, 0});
    send_vertex('{0, 0, 0, 16'sd256, 0, 0});
    send_vertex('{16'sd256, 16'sd512, 16'sd100, 0, 0, 0});
    send_vertex('{0, 0, -16'sd256, 0, 0, 0});
    send_vertex('{0, 0, -16'sd256, 0, 0, 16'sd256});
    send_vertex('{0, 0, 16'sd256, 0, 0, 16'sd256});
    send_vertex('{16'sd256, 0, 0, 16'sd256, 0, 0});
    send_vertex('{0, 16'sd256, 16'sd1, 0, -16'sd256, 0});
    send_vertex('{16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1});
    random_vertices(380);

    write_reg(2'd3, 64'hdead_beef_0123_4567);
    load_matrix(64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff);
    random_vertices(60);
    load_matrix(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
    random_vertices(60);
    load_matrix('0, '0, '0);
    send_vertex('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5});
    random_vertices(20);
    load_matrix(64'h0000_0000_0000_f000, 64'h0000_0000_f000_0000,
                64'h0000_f000_0000_0000);
    calm <= 1;
    random_vertices(120);
    calm <= 0;
    for (int k = 0; k < 3; k++) begin
      load_matrix(random_row(), random_row(), random_row());
      random_vertices(90);
    end

    vtx_valid <= 0;
    while (sb.coords_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d vertices over %0d matrix settings, %0d degenerate results",
             sent, settings + 1, sb.degen_seen);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
